>>> sv/gf31m_pkg.sv
// ----------------------------------------------------------------------------
// gf31m_pkg
// Shared types, constants and GF(31) helpers for the extension field MAC.
// ----------------------------------------------------------------------------
package gf31m_pkg;

  localparam int COEFF_W   = 5;
  localparam int IDX_W     = 6;
  localparam int PROD_W    = 2 * COEFF_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int LEN_SHORT = 60;
  localparam int LEN_LONG  = 63;

  localparam logic [COEFF_W-1:0] FIELD_P = 5'd31;

  // -f_k mod 31 for the low terms of each reduction polynomial
  localparam logic [COEFF_W-1:0] S_TAP0 = 5'd4;   // -27
  localparam logic [COEFF_W-1:0] S_TAP1 = 5'd28;  // -3
  localparam logic [COEFF_W-1:0] S_TAP2 = 5'd30;  // -1
  localparam logic [COEFF_W-1:0] L_TAP0 = 5'd29;  // -2
  localparam logic [COEFF_W-1:0] L_TAP2 = 5'd30;  // -1

  // register index, decoded from paddr[2]
  localparam logic REG_POLY_MODE = 1'b0;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic step_en;
    logic first_step;
    logic add_acc;
    logic long_mode;
    logic emit_en;
    logic emit_last;
  } ctrl_cmd_t;

  typedef logic [COEFF_W-1:0] coeff_t;

  function automatic coeff_t canon(input coeff_t c);
    return (c == FIELD_P) ? '0 : c;
  endfunction

  // 2^5 = 1 mod 31: fold twice, then one conditional subtract
  function automatic coeff_t mod31(input logic [SUM_W-1:0] v);
    logic [6:0] s1;
    logic [5:0] s2;
    s1 = {1'b0, v[10:5]} + {2'b00, v[4:0]};
    s2 = {4'b0000, s1[6:5]} + {1'b0, s1[4:0]};
    return (s2 >= {1'b0, FIELD_P}) ? 5'(s2 - {1'b0, FIELD_P}) : s2[4:0];
  endfunction

  function automatic logic [PROD_W-1:0] mul5(input coeff_t a, input coeff_t b);
    return {5'b00000, a} * {5'b00000, b};
  endfunction

endpackage

>>> sv/gf31_extension_field_mac_top.sv
// ----------------------------------------------------------------------------
// gf31_extension_field_mac_top
// Multiply-accumulate C + A*B in GF(31)[x] modulo x^60+x^2+3x+27 or x^63+x^2+2.
// Each element of n coefficients takes n loads; after the last of them the
// sequencer makes one store read and n Horner steps on the row of lane
// multipliers, then emits through the result register. Results stream one
// per cycle while the next element loads. Results cannot be stalled.
// Reset (rst_n low, synchronous): load count, sequencer and poly_mode clear.
// ----------------------------------------------------------------------------
module gf31_extension_field_mac_top #(
  parameter int MAX_COEFFS = 63
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [gf31m_pkg::COEFF_W-1:0] in_a_coeff,
  input  logic [gf31m_pkg::COEFF_W-1:0] in_b_coeff,
  input  logic [gf31m_pkg::COEFF_W-1:0] in_acc_coeff,
  output logic                          out_valid,
  output logic [gf31m_pkg::COEFF_W-1:0] out_result_coeff,
  output logic [gf31m_pkg::IDX_W-1:0]   out_coeff_index,
  output logic                          out_last_coeff,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int AW = $clog2(MAX_COEFFS);
  localparam int CW = $clog2(MAX_COEFFS + 1);

  logic                 mode_r;
  logic                 mode_long;
  gf31m_pkg::ctrl_cmd_t cmd;
  logic [AW-1:0]        wr_idx;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        emit_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == gf31m_pkg::REG_POLY_MODE)) begin
      mode_r <= pwdata[0];
    end
  end

  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == gf31m_pkg::REG_POLY_MODE) ? {31'd0, mode_r} : 32'd0;
  assign mode_long = mode_r && (MAX_COEFFS >= gf31m_pkg::LEN_LONG);

  gf31m_ctrl #(
    .MAX_COEFFS (MAX_COEFFS),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .mode_long (mode_long),
    .busy      (busy),
    .cmd       (cmd),
    .wr_idx    (wr_idx),
    .rd_addr   (rd_addr),
    .emit_idx  (emit_idx)
  );

  gf31m_dp #(
    .MAX_COEFFS (MAX_COEFFS),
    .AW         (AW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .wr_idx           (wr_idx),
    .rd_addr          (rd_addr),
    .emit_idx         (emit_idx),
    .in_a_coeff       (in_a_coeff),
    .in_b_coeff       (in_b_coeff),
    .in_acc_coeff     (in_acc_coeff),
    .out_valid        (out_valid),
    .out_result_coeff (out_result_coeff),
    .out_coeff_index  (out_coeff_index),
    .out_last_coeff   (out_last_coeff)
  );

endmodule

>>> sv/gf31m_ctrl.sv
// ----------------------------------------------------------------------------
// gf31m_ctrl
// Sequencer: load count, Horner step count over the factor A store, and
// result emission count.
// ----------------------------------------------------------------------------
module gf31m_ctrl #(
  parameter int MAX_COEFFS = 63,
  parameter int AW = $clog2(MAX_COEFFS),
  parameter int CW = $clog2(MAX_COEFFS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 mode_long,
  output logic                 busy,
  output gf31m_pkg::ctrl_cmd_t cmd,
  output logic [AW-1:0]        wr_idx,
  output logic [AW-1:0]        rd_addr,
  output logic [AW-1:0]        emit_idx
);

  typedef enum logic {ST_LOAD, ST_CALC} state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] load_cnt_r, load_cnt_nxt;
  logic [CW-1:0] step_r, step_nxt;
  logic          long_r, long_nxt;
  logic          emit_on_r, emit_on_nxt;
  logic [CW-1:0] emit_cnt_r, emit_cnt_nxt;

  logic          accept;
  logic [CW-1:0] n_cur;
  logic [CW-1:0] n_lat;
  logic [CW-1:0] k_inc;
  logic [CW-1:0] rd_full;

  always_comb begin
    n_cur   = mode_long ? CW'(gf31m_pkg::LEN_LONG) : CW'(gf31m_pkg::LEN_SHORT);
    n_lat   = long_r ? CW'(gf31m_pkg::LEN_LONG) : CW'(gf31m_pkg::LEN_SHORT);
    busy    = (state_r == ST_CALC);
    accept  = start && !busy;
    k_inc   = load_cnt_r + CW'(1);
    rd_full = n_lat - CW'(1) - step_r;

    wr_idx   = load_cnt_r[AW-1:0];
    rd_addr  = rd_full[AW-1:0];
    emit_idx = emit_cnt_r[AW-1:0];

    cmd.wr_en      = accept;
    cmd.rd_en      = busy && (step_r < n_lat);
    cmd.step_en    = busy && (step_r != '0);
    cmd.first_step = (step_r == CW'(1));
    cmd.add_acc    = (step_r == n_lat);
    cmd.long_mode  = long_r;
    cmd.emit_en    = emit_on_r;
    cmd.emit_last  = (emit_cnt_r == n_lat - CW'(1));

    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    step_nxt     = step_r;
    long_nxt     = long_r;
    emit_on_nxt  = emit_on_r;
    emit_cnt_nxt = emit_cnt_r;

    if (emit_on_r) begin
      if (cmd.emit_last) begin
        emit_on_nxt = 1'b0;
      end else begin
        emit_cnt_nxt = emit_cnt_r + CW'(1);
      end
    end

    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (k_inc >= n_cur) begin
            load_cnt_nxt = '0;
            long_nxt     = mode_long;
            step_nxt     = '0;
            state_nxt    = ST_CALC;
          end else begin
            load_cnt_nxt = k_inc;
          end
        end
      end
      ST_CALC: begin
        if (step_r == n_lat) begin
          state_nxt    = ST_LOAD;
          emit_on_nxt  = 1'b1;
          emit_cnt_nxt = '0;
        end else begin
          step_nxt = step_r + CW'(1);
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      load_cnt_r <= '0;
      step_r     <= '0;
      long_r     <= 1'b0;
      emit_on_r  <= 1'b0;
      emit_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      step_r     <= step_nxt;
      long_r     <= long_nxt;
      emit_on_r  <= emit_on_nxt;
      emit_cnt_r <= emit_cnt_nxt;
    end
  end

endmodule

>>> sv/gf31m_dp.sv
// ----------------------------------------------------------------------------
// gf31m_dp
// Coefficient stores, a row of GF(31) multiply lanes running Horner steps
// R = R*x mod f + a_j*B (+ C on the final step), and the result register.
// ----------------------------------------------------------------------------
module gf31m_dp #(
  parameter int MAX_COEFFS = 63,
  parameter int AW = $clog2(MAX_COEFFS)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gf31m_pkg::ctrl_cmd_t              cmd,
  input  logic [AW-1:0]                     wr_idx,
  input  logic [AW-1:0]                     rd_addr,
  input  logic [AW-1:0]                     emit_idx,
  input  logic [gf31m_pkg::COEFF_W-1:0]     in_a_coeff,
  input  logic [gf31m_pkg::COEFF_W-1:0]     in_b_coeff,
  input  logic [gf31m_pkg::COEFF_W-1:0]     in_acc_coeff,
  output logic                              out_valid,
  output logic [gf31m_pkg::COEFF_W-1:0]     out_result_coeff,
  output logic [gf31m_pkg::IDX_W-1:0]       out_coeff_index,
  output logic                              out_last_coeff
);

  localparam int CW = $clog2(MAX_COEFFS + 1);

  gf31m_pkg::coeff_t a_mem [MAX_COEFFS];
  gf31m_pkg::coeff_t a_rd_r;
  gf31m_pkg::coeff_t b_r [MAX_COEFFS];
  gf31m_pkg::coeff_t c_r [MAX_COEFFS];
  gf31m_pkg::coeff_t r_r [MAX_COEFFS];
  gf31m_pkg::coeff_t r_nxt [MAX_COEFFS];

  gf31m_pkg::coeff_t     top_t;
  logic [CW-1:0]         n_len;

  logic                              out_valid_r;
  gf31m_pkg::coeff_t                 out_coeff_r;
  logic [gf31m_pkg::IDX_W-1:0]       out_idx_r;
  logic                              out_last_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      a_mem[wr_idx] <= gf31m_pkg::canon(in_a_coeff);
    end
    if (cmd.rd_en) begin
      a_rd_r <= a_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      b_r[wr_idx] <= gf31m_pkg::canon(in_b_coeff);
      c_r[wr_idx] <= gf31m_pkg::canon(in_acc_coeff);
    end
  end

  always_comb begin
    n_len = cmd.long_mode ? CW'(gf31m_pkg::LEN_LONG) : CW'(gf31m_pkg::LEN_SHORT);
    if (cmd.first_step) begin
      top_t = '0;
    end else if (cmd.long_mode) begin
      top_t = r_r[MAX_COEFFS-1];
    end else begin
      top_t = r_r[gf31m_pkg::LEN_SHORT-1];
    end
  end

  for (genvar g = 0; g < MAX_COEFFS; g++) begin : g_lane
    gf31m_pkg::coeff_t                 prev;
    gf31m_pkg::coeff_t                 tap_k;
    gf31m_pkg::coeff_t                 acc_c;
    logic [gf31m_pkg::SUM_W-1:0]       sum;

    always_comb begin
      if (g == 0 || cmd.first_step) begin
        prev = '0;
      end else begin
        prev = r_r[(g == 0) ? 0 : g - 1];
      end
      if (g == 0) begin
        tap_k = cmd.long_mode ? gf31m_pkg::L_TAP0 : gf31m_pkg::S_TAP0;
      end else if (g == 1) begin
        tap_k = cmd.long_mode ? '0 : gf31m_pkg::S_TAP1;
      end else if (g == 2) begin
        tap_k = cmd.long_mode ? gf31m_pkg::L_TAP2 : gf31m_pkg::S_TAP2;
      end else begin
        tap_k = '0;
      end
      acc_c = cmd.add_acc ? c_r[g] : '0;
      sum = {1'b0, gf31m_pkg::mul5(a_rd_r, b_r[g])}
          + {1'b0, gf31m_pkg::mul5(top_t, tap_k)}
          + {6'b000000, prev}
          + {6'b000000, acc_c};
      if (g < int'(n_len)) begin
        r_nxt[g] = gf31m_pkg::mod31(sum);
      end else begin
        r_nxt[g] = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.step_en) begin
        r_r[g] <= r_nxt[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_en;
    end
    out_coeff_r <= r_r[emit_idx];
    out_idx_r   <= gf31m_pkg::IDX_W'(emit_idx);
    out_last_r  <= cmd.emit_last;
  end

  assign out_valid        = out_valid_r;
  assign out_result_coeff = out_coeff_r;
  assign out_coeff_index  = out_idx_r;
  assign out_last_coeff   = out_last_r;

endmodule
